@@ rtl/lpms_pkg.sv @@
// ----------------------------------------------------------------------------
// Low power mode selector package
// Shared types, register indexes, state encoding and the sleep mode table.
// ----------------------------------------------------------------------------
package lpms_pkg;

  localparam int NUM_DEVS_DEF = 16;
  localparam int NUM_MODES    = 6;
  localparam int IDLE_W       = 16;
  localparam int CFG_AW       = 4;

  typedef logic [2:0] mode_idx_t;
  typedef logic [NUM_MODES-1:0] mode_vec_t;

  localparam mode_idx_t LAST_MODE = mode_idx_t'(NUM_MODES - 1);

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_RELEASE = 2'd1,
    OP_DECIDE  = 2'd2
  } op_t;

  localparam logic [1:0] REG_MAX_JITTER = 2'd0;
  localparam logic [1:0] REG_MAX_DRIFT  = 2'd1;
  localparam logic [1:0] REG_IDLE_DEVS  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_MODE,
    ST_DELAY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        req;
    logic        rel;
    logic [7:0]  dev;
    logic [31:0] limit;
  } dev_wr_t;

  typedef struct packed {
    logic keep_ok;
    logic wake_ok;
  } mode_chk_t;

  localparam logic [63:0] RES_LSE = 64'(1000000000 / 32768);
  localparam logic [63:0] RES_TIM = 64'(1000000000 / 1000000);
  localparam logic [63:0] RES_WFI = 64'd16000000000 / 64'd1000000;

  function automatic logic [63:0] mode_res(input mode_idx_t m);
    case (m)
      3'd0, 3'd1, 3'd2, 3'd3: mode_res = RES_LSE;
      3'd4: mode_res = RES_TIM;
      3'd5: mode_res = RES_WFI;
      default: mode_res = RES_WFI;
    endcase
  endfunction

  function automatic logic [63:0] mode_wake(input mode_idx_t m);
    case (m)
      3'd0: mode_wake = 64'd407000;
      3'd1: mode_wake = 64'd130000;
      3'd2: mode_wake = 64'd111000;
      3'd3: mode_wake = 64'd14500;
      3'd4: mode_wake = 64'd12;
      default: mode_wake = 64'd0;
    endcase
  endfunction

  function automatic logic [19:0] mode_drift(input mode_idx_t m);
    case (m)
      3'd0, 3'd1, 3'd2, 3'd3: mode_drift = 20'd50;
      3'd4: mode_drift = 20'd30;
      default: mode_drift = 20'd0;
    endcase
  endfunction

  function automatic logic [19:0] mode_jitter(input mode_idx_t m);
    case (m)
      default: mode_jitter = 20'd0;
    endcase
  endfunction

  function automatic logic mode_idle(input mode_idx_t m);
    case (m)
      3'd4, 3'd5: mode_idle = 1'b1;
      default: mode_idle = 1'b0;
    endcase
  endfunction

  function automatic logic [63:0] mode_span(input mode_idx_t m);
    mode_span = mode_res(m) + mode_wake(m);
  endfunction

  // Bit m is set when a device with this latency limit tolerates mode m.
  function automatic mode_vec_t dev_fit(input logic [31:0] limit);
    mode_vec_t v;
    for (int m = 0; m < NUM_MODES; m++) begin
      v[m] = {32'd0, limit} >= mode_wake(mode_idx_t'(m));
    end
    dev_fit = v;
  endfunction

  function automatic mode_vec_t mode_onehot(input mode_idx_t m);
    mode_vec_t v;
    for (int k = 0; k < NUM_MODES; k++) begin
      v[k] = (m == mode_idx_t'(k));
    end
    mode_onehot = v;
  endfunction

endpackage

@@ rtl/lpms_if.sv @@
// ----------------------------------------------------------------------------
// Low power mode selector channels
// Valid/ready channel interfaces for command and result transactions.
// ----------------------------------------------------------------------------
interface lpms_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  dev_id;
  logic [31:0] max_wake_time;
  logic [63:0] wakeup_time;
  logic [63:0] cur_time;

  modport source (
    output valid, opcode, dev_id, max_wake_time, wakeup_time, cur_time,
    input  ready
  );
  modport sink (
    input  valid, opcode, dev_id, max_wake_time, wakeup_time, cur_time,
    output ready
  );
endinterface

interface lpms_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [2:0]  sleep_mode;
  logic [63:0] alarm_delay;
  logic        used_fallback;

  modport source (
    output valid, ok, sleep_mode, alarm_delay, used_fallback,
    input  ready
  );
  modport sink (
    input  valid, ok, sleep_mode, alarm_delay, used_fallback,
    output ready
  );
endinterface

@@ rtl/low_power_mode_selector_unit.sv @@
// ----------------------------------------------------------------------------
// Low power mode selector
// Tracks keep-alive devices and their wake latency limits, and picks the
// deepest usable sleep mode and its alarm delay for a decide transaction.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake             Content
//   in_if    sink       valid/ready           opcode, device, times
//   out_if   source     valid/ready           ok, mode, alarm delay, fallback
//   cfg      APB slave  psel/penable, pready  jitter, drift, idle devices
//
// A request, release or unused opcode goes straight to the result stage. A
// decide subtracts for the interval and ends there when the wakeup time has
// passed, else checks the sleep modes in turn on the shared 64-bit subtractor,
// subtracts for the alarm delay if a mode was chosen, then loads the result.
// in_if.ready is high only while idle. A stalled result waits in the output
// register while the next command runs; a further result waits until that
// register is free. Reset is synchronous.
// ----------------------------------------------------------------------------
module low_power_mode_selector_unit #(
  parameter int NUM_DEVS = lpms_pkg::NUM_DEVS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lpms_in_if.sink                     in_if,
  lpms_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpms_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lpms_pkg::*;

  state_t      state_r, state_nxt;
  logic [19:0] max_jitter_r;
  logic [19:0] max_drift_r;
  logic [15:0] idle_devs_r;

  logic [63:0] wt_r, wt_nxt;
  logic [63:0] ct_r, ct_nxt;
  logic [63:0] len_r, len_nxt;
  mode_idx_t   mode_r, mode_nxt;
  mode_idx_t   fb_r, fb_nxt;
  logic        fb_valid_r, fb_valid_nxt;
  mode_idx_t   sel_r, sel_nxt;
  logic        res_ok_r, res_ok_nxt;
  mode_idx_t   res_mode_r, res_mode_nxt;
  logic        res_fb_r, res_fb_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        in_acc;
  logic        dev_ok;
  op_t         op;
  logic        wt_set;
  logic [63:0] add_a, add_b;
  logic [64:0] diff;
  logic        borrow;
  mode_idx_t   res_idx;
  logic [63:0] res_val;
  logic        ovf;
  logic        mode_ok;
  logic        take_fb;
  logic        out_load;
  dev_wr_t     dev_wr;
  mode_chk_t   chk;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_jitter_r <= '0;
      max_drift_r  <= '0;
      idle_devs_r  <= 16'hffff;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_MAX_JITTER: max_jitter_r <= pwdata[19:0];
        REG_MAX_DRIFT:  max_drift_r  <= pwdata[19:0];
        REG_IDLE_DEVS:  idle_devs_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAX_JITTER: prdata = {12'd0, max_jitter_r};
      REG_MAX_DRIFT:  prdata = {12'd0, max_drift_r};
      REG_IDLE_DEVS:  prdata = {16'd0, idle_devs_r};
      default:        prdata = 32'd0;
    endcase
  end

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign op          = op_t'(in_if.opcode);
  assign dev_ok      = in_if.dev_id < 8'(NUM_DEVS);

  assign dev_wr.req   = in_acc && (op == OP_REQUEST) && dev_ok;
  assign dev_wr.rel   = in_acc && (op == OP_RELEASE) && dev_ok;
  assign dev_wr.dev   = in_if.dev_id;
  assign dev_wr.limit = in_if.max_wake_time;

  lpms_dev_table #(
    .NUM_DEVS(NUM_DEVS)
  ) u_dev_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (dev_wr),
    .mode     (mode_r),
    .idle_devs(idle_devs_r),
    .chk      (chk)
  );

  // Shared subtractor: interval, then mode span checks, then alarm delay.
  always_comb begin
    case (state_r)
      ST_LEN: begin
        add_a = wt_r;
        add_b = ct_r;
      end
      ST_MODE: begin
        add_a = len_r;
        add_b = mode_span(mode_r);
      end
      default: begin
        add_a = len_r;
        add_b = mode_wake(sel_r);
      end
    endcase
  end

  assign diff   = {1'b0, add_a} - {1'b0, add_b};
  assign borrow = diff[64];
  assign wt_set = (wt_r != 64'd0);

  // The interval overflows a 32-bit count exactly when its upper word
  // reaches the resolution.
  assign res_idx = (state_r == ST_DELAY) ? sel_r : mode_r;
  assign res_val = mode_res(res_idx);
  assign ovf     = len_r[63:32] >= res_val[31:0];

  assign mode_ok = !(wt_set && ((mode_jitter(mode_r) > max_jitter_r) || borrow ||
                                (mode_drift(mode_r) > max_drift_r)))
                   && chk.keep_ok && chk.wake_ok;
  assign take_fb = wt_set && ovf && !fb_valid_r;

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_if.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (op == OP_DECIDE) ? ST_LEN : ST_DONE;
        end
      end
      ST_LEN: begin
        state_nxt = (wt_set && borrow) ? ST_DONE : ST_MODE;
      end
      ST_MODE: begin
        if (mode_ok && !take_fb) begin
          state_nxt = ST_DELAY;
        end else if (mode_r == LAST_MODE) begin
          state_nxt = (fb_valid_r || mode_ok) ? ST_DELAY : ST_DONE;
        end
      end
      ST_DELAY: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    wt_nxt       = wt_r;
    ct_nxt       = ct_r;
    len_nxt      = len_r;
    mode_nxt     = mode_r;
    fb_nxt       = fb_r;
    fb_valid_nxt = fb_valid_r;
    sel_nxt      = sel_r;
    res_ok_nxt   = res_ok_r;
    res_mode_nxt = res_mode_r;
    res_fb_nxt   = res_fb_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          wt_nxt       = in_if.wakeup_time;
          ct_nxt       = in_if.cur_time;
          len_nxt      = 64'd0;
          res_ok_nxt   = ((op == OP_REQUEST) || (op == OP_RELEASE)) && dev_ok;
          res_mode_nxt = '0;
          res_fb_nxt   = 1'b0;
        end
      end
      ST_LEN: begin
        len_nxt      = (wt_set && borrow) ? 64'd0 : diff[63:0];
        mode_nxt     = '0;
        fb_valid_nxt = 1'b0;
      end
      ST_MODE: begin
        mode_nxt = mode_r + mode_idx_t'(1);
        if (mode_ok && take_fb) begin
          fb_nxt       = mode_r;
          fb_valid_nxt = 1'b1;
        end
        if (mode_ok && !take_fb) begin
          sel_nxt = mode_r;
        end else if (mode_r == LAST_MODE) begin
          if (fb_valid_r) begin
            sel_nxt = fb_r;
          end else if (mode_ok) begin
            sel_nxt = mode_r;
          end else begin
            len_nxt = 64'd0;
          end
        end
      end
      ST_DELAY: begin
        res_ok_nxt   = 1'b1;
        res_mode_nxt = sel_r;
        len_nxt      = wt_set ? diff[63:0] : 64'd0;
        res_fb_nxt   = wt_set && ovf;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_if.ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fb_valid_r  <= 1'b0;
      mode_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fb_valid_r  <= fb_valid_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wt_r       <= wt_nxt;
    ct_r       <= ct_nxt;
    len_r      <= len_nxt;
    fb_r       <= fb_nxt;
    sel_r      <= sel_nxt;
    res_ok_r   <= res_ok_nxt;
    res_mode_r <= res_mode_nxt;
    res_fb_r   <= res_fb_nxt;
    if (out_load) begin
      out_if.ok            <= res_ok_r;
      out_if.sleep_mode    <= res_mode_r;
      out_if.alarm_delay   <= len_r;
      out_if.used_fallback <= res_fb_r;
    end
  end

  assign out_if.valid = out_valid_r;

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MODE |-> mode_r <= LAST_MODE)
    else $error("mode walk ran past the last sleep mode");

  a_dev_op_short: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && op != OP_DECIDE |=> state_r == ST_DONE)
    else $error("device command did not go straight to the result stage");

  a_fb_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.used_fallback |-> out_if.ok && out_if.sleep_mode <= LAST_MODE)
    else $error("fallback flagged on a result without a chosen mode");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |=> out_valid_r && !$past(out_load))
    else $error("stalled result was overwritten");

endmodule

@@ rtl/lpms_dev_table.sv @@
// ----------------------------------------------------------------------------
// Device table
// Keep-alive mask and per-device mode tolerance flags, with the device check
// for one sleep mode.
// ----------------------------------------------------------------------------
module lpms_dev_table #(
  parameter int NUM_DEVS = lpms_pkg::NUM_DEVS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lpms_pkg::dev_wr_t   wr,
  input  lpms_pkg::mode_idx_t mode,
  input  logic [15:0]         idle_devs,
  output lpms_pkg::mode_chk_t chk
);
  import lpms_pkg::*;

  logic [NUM_DEVS-1:0] mask_r;
  mode_vec_t           fit_r [NUM_DEVS];
  logic [NUM_DEVS-1:0] avail;
  logic [NUM_DEVS-1:0] dev_ok;
  mode_vec_t           sel;

  // A stored limit of zero tolerates only the mode with no wake latency.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      for (int i = 0; i < NUM_DEVS; i++) begin
        fit_r[i] <= dev_fit(32'd0);
      end
    end else begin
      for (int i = 0; i < NUM_DEVS; i++) begin
        if (wr.req && wr.dev == 8'(i)) begin
          mask_r[i] <= 1'b1;
          fit_r[i]  <= dev_fit(wr.limit);
        end else if (wr.rel && wr.dev == 8'(i)) begin
          mask_r[i] <= 1'b0;
        end
      end
    end
  end

  for (genvar i = 0; i < NUM_DEVS; i++) begin : g_avail
    if (i < IDLE_W) begin : g_in
      assign avail[i] = idle_devs[i];
    end else begin : g_out
      assign avail[i] = 1'b0;
    end
  end

  assign sel = mode_onehot(mode);

  always_comb begin
    for (int i = 0; i < NUM_DEVS; i++) begin
      dev_ok[i] = !mask_r[i] || (|(fit_r[i] & sel));
    end
  end

  assign chk.keep_ok = mode_idle(mode) ? ((avail & mask_r) == mask_r) : (mask_r == '0);
  assign chk.wake_ok = &dev_ok;

endmodule
